[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// both sample on the rising edge of clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define MEXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mexp_pkg.sv]
package mexp_pkg;

    // width of every operand and result field on the channels
    localparam int DATA_BITS = 32;

    // microprogram address
    localparam int PC_BITS = 5;
    typedef logic [PC_BITS-1:0] pc_t;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_MM_BASE   = 4'd2;
    localparam op_t OP_MM_MUL    = 4'd3;
    localparam op_t OP_MM_SQR    = 4'd4;
    localparam op_t OP_WR_SQ     = 4'd5;
    localparam op_t OP_WR_ACC    = 4'd6;
    localparam op_t OP_WR_SQ_SHR = 4'd7;
    localparam op_t OP_OUT_OK    = 4'd8;
    localparam op_t OP_OUT_BAD   = 4'd9;

    // jump conditions
    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER     = 3'd0;
    localparam cond_t C_ALWAYS    = 3'd1;
    localparam cond_t C_NO_IN     = 3'd2;
    localparam cond_t C_M_ZERO    = 3'd3;
    localparam cond_t C_MM_BUSY   = 3'd4;
    localparam cond_t C_E_ZERO    = 3'd5;
    localparam cond_t C_E_BIT_CLR = 3'd6;
    localparam cond_t C_OUT_FULL  = 3'd7;

    // one control word of the microprogram
    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic m_zero;
        logic mm_busy;
        logic e_zero;
        logic e_bit0;
        logic out_full;
    } stat_t;

endpackage

[hw/rtl/mexp_if.sv]
// request channel: operands in
interface mexp_req_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] base;
    logic [DATA_BITS-1:0] exponent;
    logic [DATA_BITS-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink (input valid, input base, input exponent, input modulus, output ready);
endinterface

// response channel: result out
interface mexp_rsp_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] power_result;
    logic                 bad_modulus;

    modport source (output valid, output power_result, output bad_modulus, input ready);
    modport sink (input valid, input power_result, input bad_modulus, output ready);
endinterface

[hw/rtl/mexp_mulmod.sv]
`include "assert_macros.svh"

module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic [WIDTH-1:0] res
);
    // interleaved multiply: one bit of a per cycle, msb first
    // needs b < m; keeps r < m after every step
    localparam int CNT_BITS = $clog2(WIDTH + 1);
    localparam int T_BITS   = WIDTH + 2;

    logic [WIDTH-1:0]    x_reg;
    logic [WIDTH-1:0]    y_reg;
    logic [WIDTH-1:0]    r_reg;
    logic [WIDTH-1:0]    r_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;

    logic [T_BITS-1:0] t;
    logic [T_BITS-1:0] m1;
    logic [T_BITS-1:0] m2;

    // double, add, then take off zero, one or two moduli
    always_comb
    begin
        m1 = T_BITS'(m);
        m2 = m1 << 1;
        t  = (T_BITS'(r_reg) << 1) + (x_reg[WIDTH-1] ? T_BITS'(y_reg) : '0);
        if (t >= m2)
        begin
            r_next = WIDTH'(t - m2);
        end
        else if (t >= m1)
        begin
            r_next = WIDTH'(t - m1);
        end
        else
        begin
            r_next = WIDTH'(t);
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= a;
            y_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_reg << 1;
            r_reg <= r_next;
        end
    end

    // bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign res  = r_reg;

    `MEXP_ASSERT(a_no_restart, start |-> !busy_reg, "multiply started while busy")
    `MEXP_ASSERT(a_res_reduced, $fell(busy_reg) |-> (r_reg < m), "product not reduced")
    `MEXP_ASSERT(a_cnt_live, busy_reg |-> (cnt_reg != '0), "busy with no bits left")

endmodule

[hw/rtl/mexp_seq.sv]
module mexp_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  mexp_pkg::stat_t  stat,
    output mexp_pkg::uword_t uword
);
    import mexp_pkg::*;

    // program addresses
    localparam pc_t S_LOAD  = 5'd0;
    localparam pc_t S_CHKM  = 5'd1;
    localparam pc_t S_REDB  = 5'd2;
    localparam pc_t S_WREDB = 5'd3;
    localparam pc_t S_SETSQ = 5'd4;
    localparam pc_t S_LOOP  = 5'd5;
    localparam pc_t S_TBIT  = 5'd6;
    localparam pc_t S_MUL   = 5'd7;
    localparam pc_t S_WMUL  = 5'd8;
    localparam pc_t S_SETAC = 5'd9;
    localparam pc_t S_SQR   = 5'd10;
    localparam pc_t S_WSQR  = 5'd11;
    localparam pc_t S_NEXT  = 5'd12;
    localparam pc_t S_DONE  = 5'd13;
    localparam pc_t S_OUT   = 5'd14;
    localparam pc_t S_BAD   = 5'd15;
    localparam pc_t S_OUTB  = 5'd16;

    // control store
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_LOAD};
        case (pc)
            S_LOAD:  w = '{op: OP_LOAD,      cond: C_NO_IN,     target: S_LOAD};
            S_CHKM:  w = '{op: OP_NOP,       cond: C_M_ZERO,    target: S_BAD};
            S_REDB:  w = '{op: OP_MM_BASE,   cond: C_NEVER,     target: S_LOAD};
            S_WREDB: w = '{op: OP_NOP,       cond: C_MM_BUSY,   target: S_WREDB};
            S_SETSQ: w = '{op: OP_WR_SQ,     cond: C_NEVER,     target: S_LOAD};
            S_LOOP:  w = '{op: OP_NOP,       cond: C_E_ZERO,    target: S_DONE};
            S_TBIT:  w = '{op: OP_NOP,       cond: C_E_BIT_CLR, target: S_SQR};
            S_MUL:   w = '{op: OP_MM_MUL,    cond: C_NEVER,     target: S_LOAD};
            S_WMUL:  w = '{op: OP_NOP,       cond: C_MM_BUSY,   target: S_WMUL};
            S_SETAC: w = '{op: OP_WR_ACC,    cond: C_NEVER,     target: S_LOAD};
            S_SQR:   w = '{op: OP_MM_SQR,    cond: C_NEVER,     target: S_LOAD};
            S_WSQR:  w = '{op: OP_NOP,       cond: C_MM_BUSY,   target: S_WSQR};
            S_NEXT:  w = '{op: OP_WR_SQ_SHR, cond: C_ALWAYS,    target: S_LOOP};
            S_DONE:  w = '{op: OP_NOP,       cond: C_OUT_FULL,  target: S_DONE};
            S_OUT:   w = '{op: OP_OUT_OK,    cond: C_ALWAYS,    target: S_LOAD};
            S_BAD:   w = '{op: OP_NOP,       cond: C_OUT_FULL,  target: S_BAD};
            S_OUTB:  w = '{op: OP_OUT_BAD,   cond: C_ALWAYS,    target: S_LOAD};
            default: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_LOAD};
        endcase
        return w;
    endfunction

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t word;
    logic   take;

    assign word  = ucode(pc_reg);
    assign uword = word;

    // condition select
    always_comb
    begin
        case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_IN:     take = !stat.in_fire;
            C_M_ZERO:    take = stat.m_zero;
            C_MM_BUSY:   take = stat.mm_busy;
            C_E_ZERO:    take = stat.e_zero;
            C_E_BIT_CLR: take = !stat.e_bit0;
            C_OUT_FULL:  take = stat.out_full;
            default:     take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + pc_t'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[hw/rtl/modular_exponentiation.sv]
// modular exponentiation: power_result = base ^ exponent mod modulus
// req channel (valid/ready) carries base, exponent and modulus; each is taken
// as its low OPERAND_BITS bits. rsp channel returns power_result and
// bad_modulus, one beat per request beat, in order.
// a zero modulus gives bad_modulus = 1 and power_result = 0.
// a microprogram steps a bit-serial modular multiplier; the time to a
// response grows with the bit length of the exponent and its count of set
// bits, and a zero modulus is answered without the multiplier.
// one item is in work at a time; the next request beat is accepted as soon
// as the result sits in the output register, so a stalled receiver blocks
// only the item after next.
// reset returns the sequencer to its load step and empties the output register.
`include "assert_macros.svh"

module modular_exponentiation #(
    parameter int OPERAND_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    mexp_req_if.sink   req,
    mexp_rsp_if.source rsp
);
    import mexp_pkg::*;

    localparam int W = OPERAND_BITS;

    uword_t uword;
    stat_t  stat;

    logic [W-1:0] base_reg;
    logic [W-1:0] exp_reg;
    logic [W-1:0] mod_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic [W-1:0] one_mod;

    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_res;
    logic         mm_start;
    logic         mm_busy;

    logic                 rsp_valid_reg;
    logic [DATA_BITS-1:0] res_reg;
    logic                 bad_reg;
    logic                 in_fire;
    logic                 out_load;

    // sequencer
    mexp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uword (uword)
    );

    // modular multiplier
    mexp_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (mod_reg),
        .busy  (mm_busy),
        .res   (mm_res)
    );

    // handshake and status
    assign req.ready = (uword.op == OP_LOAD);
    assign in_fire   = req.valid && req.ready;
    assign out_load  = (uword.op == OP_OUT_OK) || (uword.op == OP_OUT_BAD);
    assign one_mod   = {{(W-1){1'b0}}, (mod_reg != W'(1))};

    always_comb
    begin
        stat.in_fire  = in_fire;
        stat.m_zero   = (mod_reg == '0);
        stat.mm_busy  = mm_busy;
        stat.e_zero   = (exp_reg == '0);
        stat.e_bit0   = exp_reg[0];
        stat.out_full = rsp_valid_reg;
    end

    // multiplier operand select
    always_comb
    begin
        mm_start = 1'b0;
        mm_a     = sq_reg;
        mm_b     = sq_reg;
        case (uword.op)
            OP_MM_BASE:
            begin
                mm_start = 1'b1;
                mm_a     = base_reg;
                mm_b     = one_mod;
            end
            OP_MM_MUL:
            begin
                mm_start = 1'b1;
                mm_a     = acc_reg;
                mm_b     = sq_reg;
            end
            OP_MM_SQR:
            begin
                mm_start = 1'b1;
            end
            default:
            begin
                mm_start = 1'b0;
            end
        endcase
    end

    // operand, accumulator and square registers
    always_ff @(posedge clk)
    begin
        case (uword.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    base_reg <= req.base[W-1:0];
                    exp_reg  <= req.exponent[W-1:0];
                    mod_reg  <= req.modulus[W-1:0];
                end
            end
            OP_MM_BASE:   acc_reg <= one_mod;
            OP_WR_SQ:     sq_reg  <= mm_res;
            OP_WR_ACC:    acc_reg <= mm_res;
            OP_WR_SQ_SHR:
            begin
                sq_reg  <= mm_res;
                exp_reg <= exp_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (uword.op == OP_OUT_OK)
        begin
            res_reg <= DATA_BITS'(acc_reg);
            bad_reg <= 1'b0;
        end
        else if (uword.op == OP_OUT_BAD)
        begin
            res_reg <= '0;
            bad_reg <= 1'b1;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.power_result = res_reg;
    assign rsp.bad_modulus  = bad_reg;

    `MEXP_ASSERT(a_bad_zero, (rsp_valid_reg && bad_reg) |-> (res_reg == '0), "error beat with nonzero result")
    `MEXP_ASSERT(a_load_idle, req.ready |-> !mm_busy, "load step while multiplier busy")
    `MEXP_ASSERT(a_out_free, out_load |-> !rsp_valid_reg, "result written over a waiting beat")

endmodule

[test/mexp_checker.sv]
// watches both channels of the exponentiation block, predicts every response
// beat from its request beat and compares the two in order
module mexp_checker #(
    parameter int OPERAND_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    mexp_req_if  req,
    mexp_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    import mexp_pkg::*;

    typedef struct packed {
        logic [DATA_BITS-1:0] power_result;
        logic                 bad_modulus;
    } power_t;

    // predicted responses, oldest first
    power_t pending_powers[$];

    // square-and-multiply over the exponent bits, lsb first
    function automatic power_t mod_power(
        input logic [DATA_BITS-1:0] base_in,
        input logic [DATA_BITS-1:0] exp_in,
        input logic [DATA_BITS-1:0] mod_in
    );
        logic [63:0] mask;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        power_t      r;
        int          i;
        mask = (64'd1 << OPERAND_BITS) - 64'd1;
        b = {32'd0, base_in} & mask;
        e = {32'd0, exp_in} & mask;
        m = {32'd0, mod_in} & mask;
        // zero modulus is flagged and gives no power
        if (m == 64'd0) begin
            r.power_result = '0;
            r.bad_modulus  = 1'b1;
            return r;
        end
        // a modulus of one turns every power into zero, the zero power too
        sq  = b % m;
        acc = 64'd1 % m;
        for (i = 0; i < OPERAND_BITS; i++) begin
            if (e[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        r.power_result = acc[DATA_BITS-1:0];
        r.bad_modulus  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(
        input string                field,
        input logic [DATA_BITS-1:0] got,
        input logic [DATA_BITS-1:0] want
    );
        $display("mismatch at %0t: %s got %h want %h", $time, field, got, want);
        mismatches++;
    endtask

    // response beats are matched before the request beat of the same edge
    always @(posedge clk)
    begin
        power_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_powers.size() == 0)
                    report_mismatch("unexpected beat, power_result", rsp.power_result, '0);
                else
                begin
                    want = pending_powers.pop_front();
                    if (rsp.power_result !== want.power_result)
                        report_mismatch("power_result", rsp.power_result, want.power_result);
                    if (rsp.bad_modulus !== want.bad_modulus)
                        report_mismatch("bad_modulus", {31'd0, rsp.bad_modulus},
                                        {31'd0, want.bad_modulus});
                end
            end
            if (req.valid && req.ready)
                pending_powers.push_back(mod_power(req.base, req.exponent, req.modulus));
            outstanding <= pending_powers.size();
        end
    end

endmodule

[test/tb_modular_exponentiation.sv]
module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int     OPERAND_BITS    = 32;
    localparam int     ITEMS_PER_PHASE = 600;
    localparam int     DRAIN_CYCLES    = 2400;
    localparam longint CYCLE_LIMIT     = 20_000_000;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     mismatches;
    int     outstanding;
    longint cycle_count = 0;

    mexp_req_if req();
    mexp_rsp_if rsp();

    modular_exponentiation #(
        .OPERAND_BITS(OPERAND_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    mexp_checker #(
        .OPERAND_BITS(OPERAND_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response side stalls at random
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_exponentiation verification failed");
            $finish;
        end
    end

    // one request beat, with random gaps ahead of it; valid stays high after
    // the beat so the next call decides whether it drops
    task automatic send_operands(
        input logic [DATA_BITS-1:0] b,
        input logic [DATA_BITS-1:0] e,
        input logic [DATA_BITS-1:0] m
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.base     <= b;
        req.exponent <= e;
        req.modulus  <= m;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // random operands; short exponents dominate to keep the run short
    task automatic send_random_operands();
        logic [DATA_BITS-1:0] b;
        logic [DATA_BITS-1:0] e;
        logic [DATA_BITS-1:0] m;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 4)
            m = '0;
        else if (pick < 8)
            m = 32'd1;
        else if (pick < 30)
            m = $urandom_range(255, 2);
        else if (pick < 40)
            m = 32'hFFFF_FFFF - $urandom_range(15, 0);
        else
            m = $urandom();
        pick = $urandom_range(99);
        if (pick < 10)
            b = '0;
        else if (pick < 15)
            b = 32'd1;
        else if (pick < 25)
            b = m - 32'd1;
        else if (pick < 35)
            b = m + $urandom_range(3, 0);
        else
            b = $urandom();
        pick = $urandom_range(99);
        if (pick < 55)
            e = $urandom_range(63, 0);
        else if (pick < 85)
            e = $urandom() >> $urandom_range(31, 16);
        else
            e = $urandom();
        send_operands(b, e, m);
    endtask

    // directed operands: base, exponent, modulus
    logic [95:0] directed_ops[] = '{
        {32'h0000_0005, 32'h0000_0003, 32'h0000_0000},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        {32'h0000_0007, 32'h0000_0000, 32'h0000_0001},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0007},
        {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        {32'h0000_0000, 32'h0000_0005, 32'h0000_000D},
        {32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF},
        {32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE},
        {32'h0000_0003, 32'h0000_00C8, 32'h0000_03E8},
        {32'h0012_D687, 32'h0001_0001, 32'h0000_0002},
        {32'h0000_0004, 32'h0000_000D, 32'h0000_01F1},
        {32'h0000_0064, 32'h0000_0001, 32'h0000_0007},
        {32'h8000_0000, 32'h8000_0000, 32'h8000_0001},
        {32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFB},
        {32'hDEAD_BEEF, 32'h5555_5555, 32'hAAAA_AAAB},
        {32'h1234_5678, 32'hAAAA_AAAA, 32'h7FFF_FFFF}
    };

    initial
    begin
        req.valid    <= 1'b0;
        req.base     <= '0;
        req.exponent <= '0;
        req.modulus  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats, sender busy and receiver slow
        send_idle_pct = 13;
        recv_idle_pct <= 58;
        foreach (directed_ops[i])
            send_operands(directed_ops[i][95:64], directed_ops[i][63:32],
                          directed_ops[i][31:0]);

        // random beats under three idling profiles
        repeat (ITEMS_PER_PHASE)
            send_random_operands();
        send_idle_pct = 58;
        recv_idle_pct <= 13;
        repeat (ITEMS_PER_PHASE)
            send_random_operands();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        repeat (ITEMS_PER_PHASE)
            send_random_operands();
        req.valid <= 1'b0;

        // drain
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("modular_exponentiation verification clean");
        else
            $display("modular_exponentiation verification failed");
        $finish;
    end

endmodule
